FILE: hw/rtl/spq_pkg.sv
// shared types, constants and helpers for the sorted priority queue
// no dependencies; imported by every module of the block
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int PRIO_W = 16;
    localparam int VAL_W  = 16;
    localparam int RANK_W = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_ENTRY    = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [VAL_W-1:0]         value;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic   insert;
        logic   rotate;
        entry_t new_entry;
        entry_t head_entry;
    } cell_ctrl_t;

    function automatic logic [RANK_W-1:0] to_rank(input logic [CNT_W-1:0] x);
        logic [CNT_W+RANK_W-1:0] wide;
        wide = {{RANK_W{1'b0}}, x};
        return wide[RANK_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/sorted_priority_queue_core.sv
// Sorted priority queue holding up to DEPTH (priority, value) pairs in a chain of cells,
// ordered by descending signed priority, equal priorities in arrival order. In an insert
// every cell compares against the new priority at once and the chain shifts in a single
// step, so inserts are accepted on consecutive cycles while no read-out is running, and
// each gives its one result in the following cycle. In a read-out the chain rotates one
// entry past the head per cycle, and busy stays high until the last entry has been put
// out. Results appear for one cycle each with result_valid high and cannot be held off
// by the receiver.
// depends on spq_pkg and spq_cell
module sorted_priority_queue_core
    import spq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     kind,
    input  logic signed [PRIO_W-1:0] priority_req,
    input  logic [VAL_W-1:0]         item_value,
    output logic                     result_valid,
    output logic [1:0]               status,
    output logic [RANK_W-1:0]        rank,
    output logic signed [PRIO_W-1:0] out_priority,
    output logic [VAL_W-1:0]         out_value,
    output logic                     last
);

    state_t state_reg;
    state_t state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    logic                     rvalid_reg;
    logic                     rvalid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [RANK_W-1:0]        rank_reg;
    logic [RANK_W-1:0]        rank_next;
    entry_t                   rentry_reg;
    entry_t                   rentry_next;
    logic                     last_reg;
    logic                     last_next;

    cell_ctrl_t       ctrl;
    logic [DEPTH-1:0] keep;
    logic [DEPTH-1:0] valid;
    entry_t           entry [DEPTH];

    logic             accept;
    logic             full;
    logic             do_insert;
    logic             first_read;
    logic             emit;
    logic [CNT_W-1:0] emit_idx;
    logic [CNT_W-1:0] ins_pos;

    assign busy       = (state_reg == S_READ);
    assign accept     = start && !busy;
    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign do_insert  = accept && (kind == KIND_INSERT) && !full;
    assign first_read = accept && (kind == KIND_READ) && (fill_reg != '0);
    assign emit       = first_read || (state_reg == S_READ);
    assign emit_idx   = first_read ? '0 : cnt_reg;

    assign ctrl.insert           = do_insert;
    assign ctrl.rotate           = emit;
    assign ctrl.new_entry.prio   = priority_req;
    assign ctrl.new_entry.value  = item_value;
    assign ctrl.head_entry       = entry[0];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic   lk;
            logic   lv;
            entry_t le;
            logic   rv;
            entry_t re;
            if (g == 0)
            begin : g_first
                assign lk = 1'b1;
                assign lv = 1'b0;
                assign le = entry[0];
            end
            else
            begin : g_mid
                assign lk = keep[g-1];
                assign lv = valid[g-1];
                assign le = entry[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign rv = 1'b0;
                assign re = entry[g];
            end
            else
            begin : g_inner
                assign rv = valid[g+1];
                assign re = entry[g+1];
            end
            spq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_keep  (lk),
                .left_valid (lv),
                .left_entry (le),
                .right_valid(rv),
                .right_entry(re),
                .keep       (keep[g]),
                .valid      (valid[g]),
                .entry      (entry[g])
            );
        end
    endgenerate

    // keep bits form a run from the head, so the insert position is its length
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (keep[i])
            begin
                ins_pos = CNT_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        fill_next   = fill_reg;
        rvalid_next = 1'b0;
        status_next = status_reg;
        rank_next   = rank_reg;
        rentry_next = rentry_reg;
        last_next   = last_reg;

        if (do_insert)
        begin
            fill_next = fill_reg + 1'b1;
        end

        if (accept && (kind == KIND_INSERT))
        begin
            rvalid_next       = 1'b1;
            status_next       = full ? ST_FULL : ST_INSERTED;
            rank_next         = full ? '0 : to_rank(ins_pos);
            rentry_next.prio  = '0;
            rentry_next.value = '0;
            last_next         = 1'b1;
        end
        else if (accept && !first_read)
        begin
            rvalid_next       = 1'b1;
            status_next       = ST_EMPTY;
            rank_next         = '0;
            rentry_next.prio  = '0;
            rentry_next.value = '0;
            last_next         = 1'b1;
        end
        else if (emit)
        begin
            rvalid_next = 1'b1;
            status_next = ST_ENTRY;
            rank_next   = to_rank(emit_idx);
            rentry_next = entry[0];
            last_next   = (emit_idx == fill_reg - 1'b1);
            cnt_next    = emit_idx + 1'b1;
            state_next  = last_next ? S_IDLE : S_READ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            fill_reg   <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            fill_reg   <= fill_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rank_reg   <= rank_next;
        rentry_reg <= rentry_next;
        last_reg   <= last_next;
    end

    assign result_valid = rvalid_reg;
    assign status       = status_reg;
    assign rank         = rank_reg;
    assign out_priority = rentry_reg.prio;
    assign out_value    = rentry_reg.value;
    assign last         = last_reg;

endmodule

FILE: hw/rtl/spq_cell.sv
// one slot of the sorted chain: holds an entry and its valid bit
// depends on spq_pkg
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       left_keep,
    input  logic       left_valid,
    input  entry_t     left_entry,
    input  logic       right_valid,
    input  entry_t     right_entry,
    output logic       keep,
    output logic       valid,
    output entry_t     entry
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;

    // stored entry stays ahead of the new one (equal priority keeps arrival order)
    assign keep = valid_reg && (entry_reg.prio >= ctrl.new_entry.prio);

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.insert && !keep)
        begin
            if (left_keep)
            begin
                valid_next = 1'b1;
                entry_next = ctrl.new_entry;
            end
            else
            begin
                valid_next = left_valid;
                entry_next = left_entry;
            end
        end
        else if (ctrl.rotate && valid_reg)
        begin
            // last occupied slot wraps around to the head entry
            entry_next = right_valid ? right_entry : ctrl.head_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

FILE: hw/rtl/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_core
module spq_checker
    import spq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     result_valid,
    input logic [1:0]               status,
    input logic [RANK_W-1:0]        rank,
    input logic signed [PRIO_W-1:0] out_priority,
    input logic [VAL_W-1:0]         out_value,
    input logic                     last
);

    // every transaction gives its first result in the next cycle
    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> result_valid)
        else $error("no result after accepted transaction");

    // read-out ends together with its last entry
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last && (status == ST_ENTRY))
        else $error("busy dropped without final entry");

    // an entry that is not the last keeps the block busy
    a_more_entries: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_ENTRY) && !last |-> busy)
        else $error("read-out stopped early");

    // single-result transactions carry last and zero payload
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_ENTRY) |->
            last && (out_priority == '0) && (out_value == '0))
        else $error("bad status-only result");

    // ranks of a read-out count up by one
    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_ENTRY) && !last |=>
            result_valid && (status == ST_ENTRY) && (rank == $past(rank) + 1'b1))
        else $error("read-out rank out of sequence");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
